[hw/rtl/lottery_scheduler_table_macros.svh]
// ----------------------------------------------------------------------------
// Lottery scheduler table assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_SCHEDULER_TABLE_MACROS_SVH
`define LOTTERY_SCHEDULER_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LST_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/lst_pkg.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table package
// Field widths, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lst_pkg;

   // Default table size and number of priority levels.
   localparam int unsigned TABLE_DEPTH_DEFAULT     = 32;
   localparam int unsigned PRIORITY_LEVELS_DEFAULT = 4;

   // Fixed field widths.
   localparam int unsigned ID_W     = 22;
   localparam int unsigned PRIO_W   = 2;
   localparam int unsigned RAND_W   = 31;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 2;

   // Stream payload widths.
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 32;

   // Operation codes carried with each request.
   typedef enum logic [CMD_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PICK   = 2'd2
   } lst_op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } lst_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REM_SCAN,
      S_REM_SHIFT,
      S_PICK_SUM,
      S_PICK_DIV,
      S_PICK_SCAN,
      S_RESP
   } lst_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           insert_write;
      logic           scan_start;
      logic           scan_next;
      logic           scan_run;
      logic           shift_write;
      logic           sum_acc;
      logic           div_start;
      logic           div_step;
      logic           acc_clear;
      logic           pick_acc;
      logic           count_inc;
      logic           count_dec;
      logic           res_set;
      lst_status_type res_code;
      logic           chosen_set;
      logic           rsp_load;
   } lst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic data_valid;
      logic scan_done;
      logic id_match;
      logic div_last;
      logic ticket_hit;
      logic rsp_busy;
   } lst_stat_type;

endpackage

[hw/rtl/lst_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lst_ctrl.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table controller
// Sequences insert, remove and pick operations over the datapath and
// hands each result to the output register.
// ----------------------------------------------------------------------------
`include "lottery_scheduler_table_macros.svh"

module lst_ctrl
   import lst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [CMD_W-1:0]   req_cmd,
   input  lst_stat_type       stat,
   output lst_cmd_type        cmd
);

   lst_state_type state_ff;
   lst_state_type state_in;
   logic          accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (lst_op_type'(req_cmd))
                  OP_INSERT: state_in = S_INSERT;
                  OP_REMOVE: state_in = S_REM_SCAN;
                  OP_PICK:   state_in = S_PICK_SUM;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_INSERT: begin
            state_in = S_RESP;
         end
         S_REM_SCAN: begin
            if (stat.id_match) begin
               state_in = S_REM_SHIFT;
            end else if (stat.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_REM_SHIFT: begin
            if (stat.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_PICK_SUM: begin
            if (stat.scan_done) begin
               state_in = stat.empty ? S_RESP : S_PICK_DIV;
            end
         end
         S_PICK_DIV: begin
            if (stat.div_last) begin
               state_in = S_PICK_SCAN;
            end
         end
         S_PICK_SCAN: begin
            if (stat.ticket_hit || stat.scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      cmd.res_code = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_cmd == OP_REMOVE || req_cmd == OP_PICK) begin
                  cmd.scan_start = 1'b1;
                  cmd.acc_clear  = 1'b1;
               end
            end
         end
         S_INSERT: begin
            if (stat.full) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_FULL;
            end else begin
               cmd.insert_write = 1'b1;
               cmd.count_inc    = 1'b1;
            end
         end
         S_REM_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.id_match) begin
               cmd.scan_start = 1'b1;
               cmd.scan_next  = 1'b1;
            end else if (stat.scan_done) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = ST_NOT_FOUND;
            end
         end
         S_REM_SHIFT: begin
            cmd.scan_run    = 1'b1;
            cmd.shift_write = stat.data_valid;
            cmd.count_dec   = stat.scan_done;
         end
         S_PICK_SUM: begin
            cmd.scan_run = 1'b1;
            cmd.sum_acc  = stat.data_valid;
            if (stat.scan_done) begin
               if (stat.empty) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = ST_EMPTY;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         S_PICK_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.scan_start = 1'b1;
               cmd.acc_clear  = 1'b1;
            end
         end
         S_PICK_SCAN: begin
            cmd.scan_run   = 1'b1;
            cmd.pick_acc   = stat.data_valid;
            cmd.chosen_set = stat.ticket_hit;
         end
         S_RESP: begin
            cmd.rsp_load = !stat.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Every accepted request leaves the idle state.
   `LST_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != S_IDLE, "request stayed idle")
   // A result is only loaded when the output register can take it.
   `LST_ASSERT_SAME(a_load_when_free, cmd.rsp_load, !stat.rsp_busy, "result overwrote output")

endmodule

[hw/rtl/lst_datapath.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table datapath
// Entry memory, entry count, scan pointer, ticket accumulator, bit-serial
// remainder unit and the result output register.
// ----------------------------------------------------------------------------
`include "lottery_scheduler_table_macros.svh"

module lst_datapath
   import lst_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS = PRIORITY_LEVELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  lst_cmd_type           cmd,
   output lst_stat_type          stat,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int unsigned AW    = $clog2(TABLE_DEPTH);
   localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PW    = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int unsigned TW    = $clog2(TABLE_DEPTH * PRIORITY_LEVELS + 1);
   localparam int unsigned EW    = ID_W + PW;
   localparam int unsigned DCW   = $clog2(RAND_W);
   localparam int unsigned P_TOP = PRIORITY_LEVELS - 1;

   // Request fields.
   logic [ID_W-1:0]   req_id;
   logic [PRIO_W-1:0] req_prio;
   logic [RAND_W-1:0] req_rand;

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_prio = req_tdata[ID_W+PRIO_W-1:ID_W];
   assign req_rand = req_tdata[ID_W+PRIO_W+RAND_W-1:ID_W+PRIO_W];

   // Captured request and working registers.
   logic [ID_W-1:0]      id_ff;
   logic [PW-1:0]        prio_ff;
   logic [RAND_W-1:0]    rnd_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        addr_ff;
   logic                 rd_valid_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic [TW-1:0]        acc_ff;
   logic [TW-1:0]        rem_ff;
   logic [DCW-1:0]       div_cnt_ff;
   lst_status_type       res_status_ff;
   logic [ID_W-1:0]      chosen_ff;
   logic                 rsp_valid_ff;
   lst_status_type       rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [PW-1:0]        prio_clamped;
   logic                 issue;
   logic [EW-1:0]        rd_data;
   logic [ID_W-1:0]      rd_id;
   logic [PW-1:0]        rd_prio;
   logic [TW-1:0]        weight;
   logic [TW:0]          acc_next;
   logic [TW:0]          trial;
   logic                 trial_ge;
   logic [TW-1:0]        rem_in;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;

   // Priority saturates at the top level.
   assign prio_clamped = (32'(req_prio) > P_TOP) ? PW'(P_TOP) : PW'(req_prio);

   // Scan reads entries below the count, one per cycle.
   assign issue   = cmd.scan_run && !cmd.scan_start && (addr_ff < count_ff);
   assign rd_id   = rd_data[ID_W-1:0];
   assign rd_prio = rd_data[EW-1:ID_W];
   assign weight  = TW'(rd_prio) + TW'(1);
   assign acc_next = {1'b0, acc_ff} + {1'b0, weight};

   // One restoring step of the ticket remainder.
   assign trial    = {rem_ff, rnd_ff[RAND_W-1]};
   assign trial_ge = trial >= {1'b0, acc_ff};
   assign rem_in   = trial_ge ? TW'(trial - {1'b0, acc_ff}) : TW'(trial);

   // Memory write: append on insert, move down by one while shifting.
   assign wr_en   = cmd.insert_write || cmd.shift_write;
   assign wr_addr = cmd.insert_write ? count_ff[AW-1:0] : (rd_idx_ff - AW'(1));
   assign wr_data = cmd.insert_write ? {prio_ff, id_ff} : rd_data;

   lst_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.count_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CW'(1);
         end
         rd_valid_ff <= issue;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff         <= req_id;
         prio_ff       <= prio_clamped;
         rnd_ff        <= req_rand;
         res_status_ff <= ST_OK;
         chosen_ff     <= '0;
      end else begin
         if (cmd.div_step) begin
            rnd_ff <= {rnd_ff[RAND_W-2:0], 1'b0};
         end
         if (cmd.res_set) begin
            res_status_ff <= cmd.res_code;
         end
         if (cmd.chosen_set) begin
            chosen_ff <= rd_id;
         end
      end

      // Scan pointer.
      if (cmd.scan_start) begin
         addr_ff <= cmd.scan_next ? (CW'(rd_idx_ff) + CW'(1)) : '0;
      end else if (issue) begin
         addr_ff <= addr_ff + CW'(1);
      end
      if (issue) begin
         rd_idx_ff <= addr_ff[AW-1:0];
      end

      // Ticket accumulator.
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (cmd.sum_acc || cmd.pick_acc) begin
         acc_ff <= TW'(acc_next);
      end

      // Remainder unit.
      if (cmd.div_start) begin
         rem_ff     <= '0;
         div_cnt_ff <= DCW'(RAND_W - 1);
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff - DCW'(1);
      end

      // Output register.
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= chosen_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   // Status to the controller.
   always_comb begin
      stat            = '0;
      stat.full       = (count_ff == CW'(TABLE_DEPTH));
      stat.empty      = (count_ff == '0);
      stat.data_valid = rd_valid_ff;
      stat.scan_done  = !rd_valid_ff && !issue && !(addr_ff < count_ff);
      stat.id_match   = rd_valid_ff && (rd_id == id_ff);
      stat.div_last   = (div_cnt_ff == '0);
      stat.ticket_hit = rd_valid_ff && ({1'b0, rem_ff} < acc_next);
      stat.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ID_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_id_ff};

   // An append never happens on a full table.
   `LST_ASSERT_SAME(a_no_insert_full, cmd.count_inc, count_ff < CW'(TABLE_DEPTH), "insert when full")
   // A removal never happens on an empty table.
   `LST_ASSERT_SAME(a_no_remove_empty, cmd.count_dec, count_ff != '0, "remove when empty")
   // A taken result without a new one leaves the output empty.
   `LST_ASSERT_NEXT(a_rsp_drains, rsp_valid_ff && rsp_tready && !cmd.rsp_load, !rsp_valid_ff, "stale result")

endmodule

[hw/rtl/lottery_scheduler_table.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table
// Task table with append, remove-and-compact and weighted random pick.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result per request.
// A remove scans the table from the front and then moves every later entry
// down one place. A pick walks the table once to sum the tickets, forms the
// ticket number with a 31-step bit-serial remainder, and walks the table
// again up to the winner. A new request is taken while the last result
// still waits in the output register. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module lottery_scheduler_table
   import lst_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS = PRIORITY_LEVELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // task_id [21:0], task_priority [23:22], random_value [54:24], zero [55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // chosen_id [21:0], entry_count [27:22], zero [31:28]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   lst_cmd_type  cmd;
   lst_stat_type stat;

   lst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   lst_datapath #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .PRIORITY_LEVELS (PRIORITY_LEVELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[tb/lottery_scheduler_table_checker.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table checker
// Watches the request and response streams and keeps its own copy of the
// task table. Each request transfer predicts one response, which waits in
// order. Each response transfer is compared field by field with the oldest
// prediction. Failures and a few coverage tallies are handed to the top.
// ----------------------------------------------------------------------------
module lottery_scheduler_table_checker
   import lst_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH     = TABLE_DEPTH_DEFAULT,
   parameter int unsigned PRIORITY_LEVELS = PRIORITY_LEVELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   output int                    error_count,
   output int                    pending_results,
   output int                    results_seen,
   output int                    full_seen,
   output int                    not_found_seen,
   output int                    empty_seen,
   output int                    peak_entries
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted response.
   typedef struct packed {
      lst_status_type     status;
      logic [ID_W-1:0]    chosen_id;
      logic [COUNT_W-1:0] entry_count;
   } sched_result_type;

   sched_result_type  predicted_q[$];
   sched_result_type  oldest;
   logic [ID_W-1:0]   sched_ids   [TABLE_DEPTH];
   logic [PRIO_W-1:0] sched_prios [TABLE_DEPTH];
   int unsigned       sched_count;

   initial begin
      error_count     = 0;
      pending_results = 0;
      results_seen    = 0;
      full_seen       = 0;
      not_found_seen  = 0;
      empty_seen      = 0;
      peak_entries    = 0;
      sched_count     = 0;
   end

   // Apply one request to the shadow table and return the response it causes.
   function automatic sched_result_type schedule_step(input logic [CMD_W-1:0]  op,
                                                      input logic [ID_W-1:0]   id,
                                                      input logic [PRIO_W-1:0] prio,
                                                      input logic [RAND_W-1:0] rnd);
      sched_result_type res;
      int unsigned      hit;
      int unsigned      total;
      int unsigned      ticket;
      int unsigned      acc;
      logic             found;
      res.status    = ST_OK;
      res.chosen_id = '0;
      case (op)
         OP_INSERT: begin
            if (sched_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               sched_ids[sched_count]   = id;
               // Priorities above the level range saturate at the top level.
               sched_prios[sched_count] = (prio > PRIORITY_LEVELS - 1) ?
                                          PRIO_W'(PRIORITY_LEVELS - 1) : prio;
               sched_count++;
            end
         end
         OP_REMOVE: begin
            // Only the first matching entry goes; later entries move down.
            hit = sched_count;
            for (int i = 0; i < sched_count; i++) begin
               if (hit == sched_count && sched_ids[i] == id) hit = i;
            end
            if (hit == sched_count) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (int k = hit; k + 1 < sched_count; k++) begin
                  sched_ids[k]   = sched_ids[k + 1];
                  sched_prios[k] = sched_prios[k + 1];
               end
               sched_count--;
            end
         end
         OP_PICK: begin
            if (sched_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               // Each entry holds priority+1 consecutive tickets in table order.
               total = 0;
               for (int i = 0; i < sched_count; i++) total += sched_prios[i] + 1;
               ticket = rnd % total;
               acc    = 0;
               found  = 1'b0;
               for (int i = 0; i < sched_count; i++) begin
                  if (!found) begin
                     acc += sched_prios[i] + 1;
                     if (ticket < acc) begin
                        res.chosen_id = sched_ids[i];
                        found         = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            // An unused command code leaves the table alone.
         end
      endcase
      res.entry_count = sched_count[COUNT_W-1:0];
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, want, got);
         error_count++;
      end
   endtask

   // Predict on each request transfer and compare on each response transfer.
   always @(posedge clock) begin
      if (reset) begin
         predicted_q.delete();
         sched_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_q.push_back(schedule_step(req_tuser, req_tdata[ID_W-1:0],
                                                req_tdata[ID_W +: PRIO_W],
                                                req_tdata[ID_W+PRIO_W +: RAND_W]));
            if (sched_count > peak_entries) peak_entries = sched_count;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_q.size() == 0) begin
               $display("%0t ns: response with no request outstanding, status %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               oldest = predicted_q.pop_front();
               results_seen++;
               case (oldest.status)
                  ST_FULL:      full_seen++;
                  ST_NOT_FOUND: not_found_seen++;
                  ST_EMPTY:     empty_seen++;
                  default:      ;
               endcase
               check_field("status", 32'(oldest.status), 32'(rsp_tuser));
               check_field("chosen_id", 32'(oldest.chosen_id), 32'(rsp_tdata[ID_W-1:0]));
               check_field("entry_count", 32'(oldest.entry_count),
                           32'(rsp_tdata[ID_W +: COUNT_W]));
               check_field("response padding", 32'd0,
                           32'(rsp_tdata[RSP_DATA_W-1:ID_W+COUNT_W]));
            end
         end
      end
      pending_results = predicted_q.size();
   end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Lottery scheduler table testbench
// Drives insert, remove and pick requests into the table, first a short
// directed sequence through the corner cases, then bursts that fill, drain
// and churn the table under three idle profiles and one long output stall.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
   import lst_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
   localparam int               RESET_CYCLES    = 11;
   localparam int               RUN_LIMIT       = 1_000_000;
   localparam int               DRAIN_CYCLES    = 150;
   localparam int               ITEMS_PER_PHASE = 540;
   localparam int               HOLD_CYCLES     = 300;
   localparam int               ID_POOL_SIZE    = 8;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   int error_count;
   int pending_results;
   int results_seen;
   int full_seen;
   int not_found_seen;
   int empty_seen;
   int peak_entries;

   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_left     = 0;
   int              cycle_count   = 0;
   int              items_sent    = 0;
   int              burst_left    = 0;
   burst_kind_type  burst_kind    = BURST_FILL;
   logic [ID_W-1:0] wide_ids [ID_POOL_SIZE];

   lottery_scheduler_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lottery_scheduler_table_checker sched_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .error_count     (error_count),
      .pending_results (pending_results),
      .results_seen    (results_seen),
      .full_seen       (full_seen),
      .not_found_seen  (not_found_seen),
      .empty_seen      (empty_seen),
      .peak_entries    (peak_entries)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit in case the block stops answering.
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, pending_results);
      $display("simulation failed");
      $finish;
   end

   // Response side: random back-pressure, or a counted long hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one request and return at the falling edge after its transfer.
   task automatic send_item(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio, input logic [RAND_W-1:0] rnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = REQ_DATA_W'({rnd, prio, id});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the request side until every predicted response has arrived.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   // Mostly small ids so removes find their targets, some wide ones, a few
   // random ids that are rarely present.
   function automatic logic [ID_W-1:0] draw_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return ID_W'($urandom_range(15));
      if (roll < 95) return wide_ids[$urandom_range(ID_POOL_SIZE - 1)];
      return ID_W'($urandom);
   endfunction

   function automatic logic [RAND_W-1:0] draw_rand();
      if ($urandom_range(1) == 0) return RAND_W'($urandom_range(255));
      return RAND_W'($urandom);
   endfunction

   // Random requests in bursts that grow, shrink or churn the table.
   task automatic run_random(input int n_items);
      int               roll;
      logic [CMD_W-1:0] op;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_kind = burst_kind_type'($urandom_range(2));
            burst_left = $urandom_range(20, 60);
         end
         roll = $urandom_range(99);
         case (burst_kind)
            BURST_FILL:  op = (roll < 80) ? OP_INSERT : (roll < 90) ? OP_PICK : OP_REMOVE;
            BURST_DRAIN: op = (roll < 65) ? OP_REMOVE : (roll < 85) ? OP_PICK : OP_INSERT;
            default: begin
               if (roll < 35)      op = OP_INSERT;
               else if (roll < 65) op = OP_REMOVE;
               else if (roll < 95) op = OP_PICK;
               else                op = CMD_UNUSED;
            end
         endcase
         send_item(op, draw_id(), PRIO_W'($urandom_range(3)), draw_rand());
         burst_left--;
      end
   endtask

   // Short directed pass over the corner cases.
   task automatic run_directed();
      send_item(OP_PICK, '0, '0, '0);                    // pick on an empty table
      send_item(OP_REMOVE, ID_W'(5), '0, '0);            // remove from an empty table
      send_item(CMD_UNUSED, '0, '0, '0);                 // unused code, nothing stored
      send_item(OP_INSERT, '0, 2'd0, '0);
      send_item(OP_INSERT, '1, 2'd3, '1);
      send_item(OP_INSERT, ID_W'(22'h155555), 2'd1, '0);
      send_item(OP_INSERT, ID_W'(22'h2AAAAA), 2'd2, '0);
      send_item(OP_INSERT, '0, 2'd2, '0);                // duplicate id
      send_item(OP_PICK, '0, '0, '0);
      send_item(OP_PICK, '0, '0, '1);
      send_item(OP_PICK, '0, '0, RAND_W'(31'h2AAAAAAA));
      send_item(OP_REMOVE, '0, '0, '0);                  // only the first duplicate goes
      send_item(OP_PICK, '0, '0, RAND_W'(9));
      send_item(OP_PICK, '0, '0, RAND_W'(11));
      send_item(OP_REMOVE, ID_W'(22'h123), '0, '0);      // absent id
      send_item(CMD_UNUSED, '1, 2'd3, '1);               // unused code on a busy table
      send_item(OP_REMOVE, '1, '0, '0);
      send_item(OP_REMOVE, ID_W'(22'h155555), '0, '0);
      send_item(OP_REMOVE, ID_W'(22'h2AAAAA), '0, '0);
      send_item(OP_REMOVE, '0, '0, '0);                  // table empty again
      send_item(OP_PICK, '0, '0, RAND_W'(31'h55555555));
   endtask

   // Stimulus: reset, then three phases with different idle profiles.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < ID_POOL_SIZE; i++) wide_ids[i] = ID_W'($urandom);

      // Phase one: sender idles lightly, receiver heavily.
      send_idle_pct = 30;
      recv_idle_pct = 59;
      run_directed();
      burst_kind = BURST_FILL;
      burst_left = 50;
      run_random(ITEMS_PER_PHASE);
      wait_drained();

      // Phase two: the other way round, with one long output hold-off while
      // the sender keeps offering requests.
      send_idle_pct = 59;
      recv_idle_pct = 30;
      burst_kind    = BURST_FILL;
      burst_left    = 50;
      run_random(ITEMS_PER_PHASE / 2);
      hold_left = HOLD_CYCLES;
      run_random(12);
      run_random(ITEMS_PER_PHASE / 2 - 12);
      wait_drained();

      // Phase three: no idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      burst_kind    = BURST_FILL;
      burst_left    = 50;
      run_random(ITEMS_PER_PHASE);
      wait_drained();

      // Let any stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d requests under three idle profiles and a %0d-cycle output stall;",
               items_sent, HOLD_CYCLES);
      $display("checked %0d responses: %0d full, %0d not found, %0d empty, peak %0d entries.",
               results_seen, full_seen, not_found_seen, empty_seen, peak_entries);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[lottery_scheduler_table.f]
+incdir+hw/rtl
hw/rtl/lst_pkg.sv
hw/rtl/lst_ram.sv
hw/rtl/lst_ctrl.sv
hw/rtl/lst_datapath.sv
hw/rtl/lottery_scheduler_table.sv
tb/lottery_scheduler_table_checker.sv
tb/tb_top.sv
